FILE: hw/rtl/chwd_pkg.sv
// Shared constants, codes and byte folding for the chained hash word dictionary.
package chwd_pkg;
   localparam int unsigned BUCKETS_DEF      = 26;
   localparam int unsigned MAX_WORD_LEN_DEF = 45;
   localparam int unsigned CAPACITY_DEF     = 1024;

   localparam int unsigned COUNT_W = 11;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_CHECK  = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_LONG = 2'd2;

   // Lower-case only 'A' to 'Z'.
   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'd32;
      end
      return r;
   endfunction
endpackage

FILE: hw/rtl/chained_hash_word_dictionary_top.sv
// Case-insensitive word dictionary: hash set with separate chaining.
//
// Usage: words arrive one byte per req_ transfer (req_action, req_character,
// req_last). Insert (0) and check (1) bytes are gathered; the action on the
// byte marked last decides. Clear (2) empties all buckets at once. Action 3
// is ignored. One rsp_ transfer (found, status, stored total) follows each
// last byte and each clear.
// A byte not marked last is done once the single subtractor has reduced the
// bucket sum by repeated subtraction. A last byte adds a store pass on insert
// that copies the word into the character store, or a chain walk on check
// that compares each entry's length and then its characters, one read at a
// time through the single read port of the character store. Clear runs no pass.
// req_ready is high only while the sequencer is idle. A result waits in the
// output register while the receiver stalls; a following byte is still
// taken, but the next result holds the sequencer until the register frees.
// Reset empties every bucket, zeroes the word count and drops any partial
// word; no clearing pass runs, the entry store is tracked by the count.
module chained_hash_word_dictionary_top #(
   parameter int unsigned BUCKETS      = chwd_pkg::BUCKETS_DEF,
   parameter int unsigned MAX_WORD_LEN = chwd_pkg::MAX_WORD_LEN_DEF,
   parameter int unsigned CAPACITY     = chwd_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_character,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [1:0]  rsp_status,
   output logic [chwd_pkg::COUNT_W-1:0] rsp_stored_total
);
   localparam int unsigned HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned SW = $clog2(BUCKETS + 256);
   localparam int unsigned PW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned LW = $clog2(MAX_WORD_LEN + 1);
   localparam int unsigned BW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int unsigned ED = CAPACITY * MAX_WORD_LEN;
   localparam int unsigned AW = (ED > 1) ? $clog2(ED) : 1;
   localparam logic [PW-1:0] NULL_P = PW'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE, S_HASH, S_DECIDE, S_COPY, S_WALK, S_WLEN, S_WRD, S_WCHK, S_EMIT
   } state_type;

   state_type        state_ff;
   logic [LW-1:0]    len_ff;
   logic [HW-1:0]    hash_ff;
   logic [SW-1:0]    sum_ff;
   logic             ovf_ff;
   logic             last_ff;
   logic [1:0]       act_ff;
   logic [PW-1:0]    cnt_ff;
   logic [PW-1:0]    head_ff [BUCKETS];
   logic [BUCKETS-1:0] head_vld_ff;
   logic [PW-1:0]    p_ff;
   logic [AW-1:0]    base_ff;
   logic [LW-1:0]    idx_ff;
   logic             res_found_ff;
   logic [1:0]       res_status_ff;
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [1:0]       rsp_status_ff;
   logic [chwd_pkg::COUNT_W-1:0] rsp_count_ff;

   // Memories.
   logic [7:0]       wbuf [MAX_WORD_LEN];
   logic [7:0]       echars [ED];
   logic [LW-1:0]    elen [CAPACITY];
   logic [PW-1:0]    enext [CAPACITY];
   logic [7:0]       wbuf_q_ff;
   logic [7:0]       ec_q_ff;
   logic [LW-1:0]    elen_q_ff;
   logic [PW-1:0]    enext_q_ff;
   logic             ec_we_ff;
   logic [AW-1:0]    ec_waddr_ff;

   logic             acc;
   logic [PW-1:0]    head_cur;
   logic [AW-1:0]    ec_raddr;
   logic [AW-1:0]    prod;
   logic             ins_done;

   assign acc       = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign head_cur  = head_vld_ff[hash_ff] ? head_ff[hash_ff] : NULL_P;
   assign ec_raddr  = base_ff + AW'(idx_ff);
   assign ins_done  = (state_ff == S_COPY) && (idx_ff == len_ff);
   assign prod      = (state_ff == S_DECIDE) ? AW'(cnt_ff) * AW'(MAX_WORD_LEN)
                                             : AW'(p_ff) * AW'(MAX_WORD_LEN);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_stored_total = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (acc && req_action != chwd_pkg::ACT_CLEAR && req_action != chwd_pkg::ACT_NONE
          && len_ff < LW'(MAX_WORD_LEN)) begin
         wbuf[len_ff[BW-1:0]] <= req_character;
      end
      wbuf_q_ff <= wbuf[idx_ff[BW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ec_we_ff) begin
         echars[ec_waddr_ff] <= wbuf_q_ff;
      end
      ec_q_ff <= echars[ec_raddr];
   end

   always_ff @(posedge clock) begin
      if (ins_done) begin
         elen[cnt_ff[IW-1:0]]  <= len_ff;
         enext[cnt_ff[IW-1:0]] <= head_cur;
      end
      elen_q_ff  <= elen[p_ff[IW-1:0]];
      enext_q_ff <= enext[p_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         hash_ff      <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         head_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         ec_we_ff     <= 1'b0;
      end else begin
         ec_we_ff <= (state_ff == S_COPY) && (idx_ff != len_ff);
         if (rsp_valid_ff && rsp_ready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  act_ff  <= req_action;
                  last_ff <= req_last;
                  case (req_action)
                     chwd_pkg::ACT_CLEAR: begin
                        len_ff        <= '0;
                        hash_ff       <= '0;
                        ovf_ff        <= 1'b0;
                        cnt_ff        <= '0;
                        head_vld_ff   <= '0;
                        res_found_ff  <= 1'b0;
                        res_status_ff <= chwd_pkg::STAT_OK;
                        state_ff      <= S_EMIT;
                     end
                     chwd_pkg::ACT_INSERT, chwd_pkg::ACT_CHECK: begin
                        if (len_ff < LW'(MAX_WORD_LEN)) begin
                           len_ff   <= len_ff + 1'b1;
                           sum_ff   <= SW'(hash_ff) + SW'(chwd_pkg::fold(req_character));
                           state_ff <= S_HASH;
                        end else begin
                           ovf_ff   <= 1'b1;
                           state_ff <= req_last ? S_DECIDE : S_IDLE;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_HASH: begin
               // Reduce the bucket sum by repeated subtraction.
               if (sum_ff >= SW'(BUCKETS)) begin
                  sum_ff <= sum_ff - SW'(BUCKETS);
               end else begin
                  hash_ff  <= HW'(sum_ff);
                  state_ff <= last_ff ? S_DECIDE : S_IDLE;
               end
            end
            S_DECIDE: begin
               res_found_ff <= 1'b0;
               idx_ff       <= '0;
               if (ovf_ff) begin
                  res_status_ff <= chwd_pkg::STAT_LONG;
                  state_ff      <= S_EMIT;
               end else if (act_ff == chwd_pkg::ACT_INSERT) begin
                  if (cnt_ff >= PW'(CAPACITY)) begin
                     res_status_ff <= chwd_pkg::STAT_FULL;
                     state_ff      <= S_EMIT;
                  end else begin
                     res_status_ff <= chwd_pkg::STAT_OK;
                     base_ff       <= prod;
                     state_ff      <= S_COPY;
                  end
               end else begin
                  res_status_ff <= chwd_pkg::STAT_OK;
                  p_ff          <= head_cur;
                  state_ff      <= S_WALK;
               end
            end
            S_COPY: begin
               if (idx_ff == len_ff) begin
                  head_ff[hash_ff]     <= cnt_ff;
                  head_vld_ff[hash_ff] <= 1'b1;
                  cnt_ff               <= cnt_ff + 1'b1;
                  state_ff             <= S_EMIT;
               end else begin
                  ec_waddr_ff <= ec_raddr;
                  idx_ff      <= idx_ff + 1'b1;
               end
            end
            S_WALK: begin
               idx_ff <= '0;
               if (p_ff >= PW'(CAPACITY)) begin
                  state_ff <= S_EMIT;
               end else begin
                  base_ff  <= prod;
                  state_ff <= S_WLEN;
               end
            end
            S_WLEN: begin
               if (elen_q_ff != len_ff) begin
                  p_ff     <= enext_q_ff;
                  state_ff <= S_WALK;
               end else begin
                  state_ff <= S_WRD;
               end
            end
            S_WRD: begin
               state_ff <= S_WCHK;
            end
            S_WCHK: begin
               if (chwd_pkg::fold(ec_q_ff) != chwd_pkg::fold(wbuf_q_ff)) begin
                  p_ff     <= enext_q_ff;
                  state_ff <= S_WALK;
               end else if (idx_ff + 1'b1 == len_ff) begin
                  res_found_ff <= 1'b1;
                  state_ff     <= S_EMIT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_WRD;
               end
            end
            S_EMIT: begin
               // Hold until the output register is free.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_found_ff  <= res_found_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_count_ff  <= chwd_pkg::COUNT_W'(cnt_ff);
                  len_ff        <= '0;
                  hash_ff       <= '0;
                  ovf_ff        <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule

FILE: hw/rtl/chwd_checker.sv
// Port-level checks for the chained hash word dictionary, bound to the top level.
module chwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_action,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [1:0]  rsp_status,
   input logic [chwd_pkg::COUNT_W-1:0] rsp_stored_total
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_status) && $stable(rsp_stored_total))
      else $error("result changed while stalled");

   // A clear or a last byte always starts work that keeps the input closed.
   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == chwd_pkg::ACT_CLEAR
         || (req_action != chwd_pkg::ACT_NONE && req_last)) |=> !req_ready)
      else $error("ready high right after a working transfer");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == chwd_pkg::STAT_OK)
      else $error("found with a failing status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == chwd_pkg::STAT_OK || rsp_status == chwd_pkg::STAT_FULL
         || rsp_status == chwd_pkg::STAT_LONG)
      else $error("undefined status code");
endmodule

bind chained_hash_word_dictionary_top chwd_checker u_chwd_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
   .req_last(req_last),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_found(rsp_found),
   .rsp_status(rsp_status), .rsp_stored_total(rsp_stored_total)
);

FILE: tb/tb_chained_hash_word_dictionary_top.sv
// Self-checking testbench for the chained hash word dictionary.
module tb_chained_hash_word_dictionary_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB   = chwd_pkg::BUCKETS_DEF;
   localparam int MAXL = chwd_pkg::MAX_WORD_LEN_DEF;
   localparam int CAP  = chwd_pkg::CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] character;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic                         found;
      logic [1:0]                   status;
      logic [chwd_pkg::COUNT_W-1:0] stored_total;
   } lookup_result_type;

   logic clock, reset;
   logic req_valid, req_ready, req_last;
   logic [1:0] req_action;
   logic [7:0] req_character;
   logic rsp_valid, rsp_ready, rsp_found;
   logic [1:0] rsp_status;
   logic [chwd_pkg::COUNT_W-1:0] rsp_stored_total;

   chained_hash_word_dictionary_top i_dut (.*);

   byte_item_type     pending_bytes[$];
   lookup_result_type expected_results[$];
   int total_items, sent_items, results_seen, errors, cycles;

   // dictionary mirror
   logic [7:0] cur_word[MAXL];
   int cur_len, cur_hash;
   bit cur_overflow;
   int chain_head[NB];
   logic [7:0] store_chars[CAP][MAXL];
   int store_len[CAP], store_next[CAP];
   int store_count;

   function automatic logic [7:0] lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic void empty_dictionary();
      for (int b = 0; b < NB; b++) chain_head[b] = CAP;
      store_count  = 0;
      cur_len      = 0;
      cur_hash     = 0;
      cur_overflow = 0;
   endfunction

   function automatic bit entry_equal(input int e);
      if (store_len[e] != cur_len) return 0;
      for (int i = 0; i < cur_len; i++)
         if (lower(store_chars[e][i]) != lower(cur_word[i])) return 0;
      return 1;
   endfunction

   // Apply one byte to the mirror; push a result where one is due.
   function automatic void predict_lookup(input byte_item_type it);
      lookup_result_type r;
      int p, guard;
      r = '0;
      if (it.action == chwd_pkg::ACT_NONE) return;
      if (it.action == chwd_pkg::ACT_CLEAR) begin
         empty_dictionary();
         expected_results.push_back(r);
         return;
      end
      if (cur_len < MAXL) begin
         cur_word[cur_len] = it.character;
         cur_len++;
         cur_hash = (cur_hash + int'(lower(it.character))) % NB;
      end else begin
         cur_overflow = 1;
      end
      if (!it.last) return;
      if (cur_overflow) begin
         r.status = chwd_pkg::STAT_LONG;
      end else if (it.action == chwd_pkg::ACT_INSERT) begin
         if (store_count >= CAP) begin
            r.status = chwd_pkg::STAT_FULL;
         end else begin
            for (int i = 0; i < cur_len; i++) store_chars[store_count][i] = cur_word[i];
            store_len[store_count]  = cur_len;
            store_next[store_count] = chain_head[cur_hash];
            chain_head[cur_hash]    = store_count;
            store_count++;
         end
      end else begin
         p = chain_head[cur_hash];
         guard = 0;
         while (p < CAP && guard < CAP) begin
            if (entry_equal(p)) begin
               r.found = 1;
               break;
            end
            p = store_next[p];
            guard++;
         end
      end
      r.stored_total = store_count[chwd_pkg::COUNT_W-1:0];
      cur_len = 0;
      cur_hash = 0;
      cur_overflow = 0;
      expected_results.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at result %0d: %s got %0d expected %0d", results_seen, what, got,
               want);
      errors++;
   endtask

   function automatic void add_byte(input logic [1:0] a, input logic [7:0] c, input logic l);
      byte_item_type it;
      it.action = a;
      it.character = c;
      it.last = l;
      pending_bytes.push_back(it);
   endfunction

   // Queue one word; unless any_byte is set, letters come from a tiny alphabet so chains and hits are common.
   function automatic void add_word(input logic [1:0] a, input int len, input bit any_byte,
                                    input bit mixed);
      logic [7:0] c;
      logic [1:0] act;
      for (int i = 0; i < len; i++) begin
         c = any_byte ? 8'($urandom_range(0, 255)) : 8'("a" + $urandom_range(0, 3));
         if (!any_byte && $urandom_range(0, 1)) c = c - 8'd32;
         act = (mixed && i != len - 1) ? 2'($urandom_range(0, 1)) : a;
         add_byte(act, c, i == len - 1);
      end
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // sender
   always @(posedge clock) begin
      int idle_pct;
      if (reset) begin
         req_valid     <= 0;
         req_action    <= chwd_pkg::ACT_NONE;
         req_character <= '0;
         req_last      <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predict_lookup({req_action, req_character, req_last});
            sent_items++;
         end
         idle_pct = (sent_items * 3 < total_items) ? 25 :
                    (sent_items * 3 < total_items * 2) ? 52 : 0;
         if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            byte_item_type it;
            it = pending_bytes.pop_front();
            req_valid     <= 1;
            req_action    <= it.action;
            req_character <= it.character;
            req_last      <= it.last;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver and result check
   always @(posedge clock) begin
      int idle_pct;
      lookup_result_type want;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         idle_pct = (sent_items * 3 < total_items) ? 52 :
                    (sent_items * 3 < total_items * 2) ? 25 : 0;
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result count", results_seen + 1, results_seen);
            end else begin
               want = expected_results.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", int'(rsp_found), int'(want.found));
               if (rsp_status !== want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_stored_total !== want.stored_total)
                  report_mismatch("stored_total", int'(rsp_stored_total),
                                  int'(want.stored_total));
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      errors = 0;
      cycles = 0;
      sent_items = 0;
      results_seen = 0;
      total_items = 1;
      empty_dictionary();
      reset = 1;

      // directed words
      add_byte(chwd_pkg::ACT_INSERT, "A", 1);
      add_byte(chwd_pkg::ACT_CHECK, "a", 1);
      add_byte(chwd_pkg::ACT_CHECK, "b", 1);
      add_byte(chwd_pkg::ACT_INSERT, 8'h00, 0);
      add_byte(chwd_pkg::ACT_INSERT, 8'hFF, 1);
      add_byte(chwd_pkg::ACT_CHECK, 8'h00, 0);
      add_byte(chwd_pkg::ACT_CHECK, 8'hFF, 1);
      add_byte(chwd_pkg::ACT_CHECK, "Z", 0);
      add_byte(chwd_pkg::ACT_INSERT, "[", 1);
      add_byte(chwd_pkg::ACT_NONE, "q", 1);
      add_byte(chwd_pkg::ACT_CHECK, "z", 0);
      add_byte(chwd_pkg::ACT_CHECK, "[", 1);
      add_word(chwd_pkg::ACT_INSERT, MAXL, 0, 0);
      add_word(chwd_pkg::ACT_INSERT, MAXL + 1, 0, 0);
      add_word(chwd_pkg::ACT_CHECK, MAXL + 1, 0, 0);
      add_byte(chwd_pkg::ACT_INSERT, "c", 0);
      add_byte(chwd_pkg::ACT_CLEAR, 8'h55, 0);
      add_byte(chwd_pkg::ACT_CHECK, "a", 1);

      // random mix
      for (int w = 0; w < 100; w++) begin
         n = $urandom_range(0, 99);
         if (n < 2) add_byte(chwd_pkg::ACT_CLEAR, 8'($urandom), 1'($urandom));
         else if (n < 4) add_byte(chwd_pkg::ACT_NONE, 8'($urandom), 1'($urandom));
         else if (n < 6)
            add_word(2'($urandom_range(0, 1)), $urandom_range(MAXL - 1, MAXL + 2), 0, 1);
         else add_word(2'($urandom_range(0, 1)), $urandom_range(1, 4), n < 20, n < 30);
      end

      // fill the store past capacity, then probe it
      add_byte(chwd_pkg::ACT_CLEAR, 8'h00, 0);
      for (int w = 0; w < CAP + 8; w++) add_word(chwd_pkg::ACT_INSERT, $urandom_range(1, 2), 0, 0);
      for (int w = 0; w < 30; w++) add_word(2'($urandom_range(0, 1)), $urandom_range(1, 3), 0, 0);
      add_byte(chwd_pkg::ACT_CLEAR, 8'hFF, 1);
      for (int w = 0; w < 20; w++) add_word(2'($urandom_range(0, 1)), $urandom_range(1, 3), 0, 1);
      total_items = pending_bytes.size();

      repeat (6) @(posedge clock);
      reset <= 0;

      wait (pending_bytes.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d bytes and checked %0d results, covering hits, misses, long words,",
               sent_items, results_seen);
      $display("store-full drops, clears, ignored bytes and mixed actions under random stalls.");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
